// File: hw/rtl/sgsd_pkg.sv
// ----------------------------------------------------------------------------
// sgsd_pkg
// Shared types and constants of the stick gesture sequence detector.
// ----------------------------------------------------------------------------
package sgsd_pkg;

  // history length and command sequence count
  localparam int HistoryDepth = 7;
  localparam int NumCommands  = 3;

  // field widths
  localparam int StickW   = 16;
  localparam int LimitW   = 15;
  localparam int TimeW    = 32;
  localparam int CommandW = 2;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // stream payload widths
  localparam int InDataW  = 3 * StickW + TimeW;
  localparam int OutDataW = 8;

  // gesture codes
  typedef enum logic [7:0] {
    G_CENTRE = 8'd0,
    G_LEFT   = 8'd1,
    G_RIGHT  = 8'd2,
    G_DOWN   = 8'd3,
    G_UP     = 8'd4,
    G_IDLE   = 8'd12,
    G_OTHER  = 8'd127,
    G_LONG   = 8'd255
  } gesture_t;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_STICK_FULL    = 3'd0,
    CFG_STICK_CENTRE  = 3'd1,
    CFG_HOLD_SHORT_US = 3'd2,
    CFG_HOLD_LONG_US  = 3'd3,
    CFG_HOLD_IDLE_US  = 3'd4,
    CFG_USE_YAW_AXIS  = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam logic [LimitW-1:0] StickFullRst   = 15'd11469;
  localparam logic [LimitW-1:0] StickCentreRst = 15'd3277;
  localparam logic [TimeW-1:0]  HoldShortRst   = 32'd100000;
  localparam logic [TimeW-1:0]  HoldLongRst    = 32'd500000;
  localparam logic [TimeW-1:0]  HoldIdleRst    = 32'd1000000;

  // expected history per command, newest entry first
  localparam gesture_t CmdSeq [NumCommands][HistoryDepth] = '{
    '{G_CENTRE, G_DOWN, G_CENTRE, G_LEFT,  G_CENTRE, G_LEFT,  G_IDLE},
    '{G_CENTRE, G_DOWN, G_CENTRE, G_RIGHT, G_CENTRE, G_RIGHT, G_IDLE},
    '{G_CENTRE, G_DOWN, G_CENTRE, G_DOWN,  G_CENTRE, G_DOWN,  G_IDLE}
  };

endpackage

// File: hw/rtl/stick_gesture_sequence_detector.sv
// ----------------------------------------------------------------------------
// stick_gesture_sequence_detector
// Classifies stick samples on the ground and detects three command gestures.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stick sample per transfer (sticks and timestamp in in_tdata,
//           on-ground flag in in_tuser).
//   out_* : one result per sample, the command number in out_tdata
//           (0 none, 1 left-left-down, 2 right-right-down, 3 down-down-down).
//   cfg_* : register writes, index in cfg_addr, value in cfg_data; always
//           ready, to be used while no sample is in flight.
// Timing: one input register, then classification, hold timing and history match
// in a single pass into the output register, so the result is registered. One
// sample per cycle is sustained while out_tready stays high; the gesture state is
// updated as a sample leaves the input register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// configuration and gesture state to their defaults.
// When out_tready is low the result holds, the input register still takes
// one more sample, and in_tready drops only once both registers are full.
// ----------------------------------------------------------------------------
module stick_gesture_sequence_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] roll_stick, [31:16] yaw_stick, [47:32] pitch_stick, [79:48] time_us
  input  logic [sgsd_pkg::InDataW-1:0]   in_tdata,
  // [0] on_ground
  input  logic                           in_tuser,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] command, [7:2] zero
  output logic [sgsd_pkg::OutDataW-1:0]  out_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgsd_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [sgsd_pkg::CfgDataW-1:0]  cfg_data
);

  import sgsd_pkg::*;

  // configuration registers
  logic [LimitW-1:0] stick_full_r;
  logic [LimitW-1:0] stick_centre_r;
  logic [TimeW-1:0]  hold_short_r;
  logic [TimeW-1:0]  hold_long_r;
  logic [TimeW-1:0]  hold_idle_r;
  logic              use_yaw_r;

  // input register
  logic                   s1_valid_r, s1_valid_nxt;
  logic [InDataW-1:0]     s1_data_r;
  logic                   s1_ground_r;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [CommandW-1:0]    out_cmd_r, out_cmd_nxt;

  // gesture state
  gesture_t               cur_class_r, cur_class_nxt;
  gesture_t               prev_class_r, prev_class_nxt;
  gesture_t               qual_r, qual_nxt;
  logic [TimeW-1:0]       hold_start_r, hold_start_nxt;
  gesture_t               hist_r [HistoryDepth];
  gesture_t               hist_nxt [HistoryDepth];

  // datapath signals
  logic                   advance;
  logic                   fire;
  logic signed [StickW-1:0] roll_s, yaw_s, pitch_s, x_s;
  logic [TimeW-1:0]       now;
  logic signed [StickW+1:0] x_e, p_e, full_e, full_neg;
  logic [StickW:0]        x_mag, p_mag, centre_e;
  logic                   xc, pc, left, right, down, up;
  logic [TimeW-1:0]       elapsed;
  logic [NumCommands-1:0] match;

  // handshake: both registers move together when the output is free
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign fire      = s1_valid_r && advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-CommandW){1'b0}}, out_cmd_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_full_r   <= StickFullRst;
      stick_centre_r <= StickCentreRst;
      hold_short_r   <= HoldShortRst;
      hold_long_r    <= HoldLongRst;
      hold_idle_r    <= HoldIdleRst;
      use_yaw_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_STICK_FULL:    stick_full_r   <= cfg_data[LimitW-1:0];
        CFG_STICK_CENTRE:  stick_centre_r <= cfg_data[LimitW-1:0];
        CFG_HOLD_SHORT_US: hold_short_r   <= cfg_data[TimeW-1:0];
        CFG_HOLD_LONG_US:  hold_long_r    <= cfg_data[TimeW-1:0];
        CFG_HOLD_IDLE_US:  hold_idle_r    <= cfg_data[TimeW-1:0];
        CFG_USE_YAW_AXIS:  use_yaw_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_comb begin
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // input payload, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r   <= in_tdata;
      s1_ground_r <= in_tuser;
    end
  end

  // unpack sample
  assign roll_s  = s1_data_r[StickW-1:0];
  assign yaw_s   = s1_data_r[2*StickW-1:StickW];
  assign pitch_s = s1_data_r[3*StickW-1:2*StickW];
  assign now     = s1_data_r[3*StickW+TimeW-1:3*StickW];
  assign x_s     = use_yaw_r ? yaw_s : roll_s;

  // magnitudes and threshold compares
  assign x_e      = {{2{x_s[StickW-1]}}, x_s};
  assign p_e      = {{2{pitch_s[StickW-1]}}, pitch_s};
  assign full_e   = {{(StickW+2-LimitW){1'b0}}, stick_full_r};
  assign full_neg = -full_e;
  assign centre_e = {{(StickW+1-LimitW){1'b0}}, stick_centre_r};
  assign x_mag    = x_e[StickW+1] ? 17'(-x_e) : 17'(x_e);
  assign p_mag    = p_e[StickW+1] ? 17'(-p_e) : 17'(p_e);
  assign xc       = x_mag < centre_e;
  assign pc       = p_mag < centre_e;
  assign left     = x_e < full_neg;
  assign right    = x_e > full_e;
  assign down     = p_e < full_neg;
  assign up       = p_e > full_e;

  // classification, hold timing and qualified gesture
  always_comb begin
    cur_class_nxt  = cur_class_r;
    prev_class_nxt = prev_class_r;
    qual_nxt       = qual_r;
    hold_start_nxt = hold_start_r;
    elapsed        = '0;
    if (!s1_ground_r) begin
      qual_nxt       = G_OTHER;
      prev_class_nxt = G_OTHER;
    end else begin
      priority if (xc && pc) begin
        cur_class_nxt = G_CENTRE;
      end else if (left && pc) begin
        cur_class_nxt = G_LEFT;
      end else if (right && pc) begin
        cur_class_nxt = G_RIGHT;
      end else if (down && xc) begin
        cur_class_nxt = G_DOWN;
      end else if (up && xc) begin
        cur_class_nxt = G_UP;
      end else begin
        cur_class_nxt = cur_class_r;
      end
      if (cur_class_nxt != prev_class_r) begin
        hold_start_nxt = now;
      end
      elapsed = now - hold_start_nxt;
      if (elapsed > hold_short_r) begin
        priority if (cur_class_nxt == G_CENTRE && elapsed > hold_idle_r) begin
          qual_nxt = G_IDLE;
        end else if (elapsed > hold_long_r) begin
          if (cur_class_nxt != G_OTHER) begin
            qual_nxt = G_LONG;
          end
        end else begin
          qual_nxt = cur_class_nxt;
        end
      end
      prev_class_nxt = cur_class_nxt;
    end
  end

  // history push and command match
  always_comb begin
    for (int i = 0; i < HistoryDepth; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    match       = '0;
    out_cmd_nxt = '0;
    if (s1_ground_r && qual_nxt != hist_r[0]) begin
      hist_nxt[0] = qual_nxt;
      for (int i = 1; i < HistoryDepth; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
      for (int c = 0; c < NumCommands; c++) begin
        match[c] = 1'b1;
        for (int i = 0; i < HistoryDepth; i++) begin
          if (hist_nxt[i] != CmdSeq[c][i]) begin
            match[c] = 1'b0;
          end
        end
      end
      priority if (match[0]) begin
        out_cmd_nxt = CommandW'(1);
      end else if (match[1]) begin
        out_cmd_nxt = CommandW'(2);
      end else if (match[2]) begin
        out_cmd_nxt = CommandW'(3);
      end else begin
        out_cmd_nxt = '0;
      end
      // spoil the history so the command does not fire again
      if (match != '0) begin
        hist_nxt[1] = G_OTHER;
      end
    end
  end

  // gesture state, updated as a sample is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_class_r  <= G_CENTRE;
      prev_class_r <= G_CENTRE;
      qual_r       <= G_CENTRE;
      hold_start_r <= '0;
      for (int i = 0; i < HistoryDepth; i++) begin
        hist_r[i] <= G_CENTRE;
      end
    end else if (fire) begin
      cur_class_r  <= cur_class_nxt;
      prev_class_r <= prev_class_nxt;
      qual_r       <= qual_nxt;
      hold_start_r <= hold_start_nxt;
      for (int i = 0; i < HistoryDepth; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  // output register
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_cmd_r <= out_cmd_nxt;
    end
  end

endmodule

// File: hw/rtl/sgsd_checker.sv
// ----------------------------------------------------------------------------
// sgsd_checker
// Port-level assertions for the stick gesture sequence detector.
// ----------------------------------------------------------------------------
module sgsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sgsd_pkg::OutDataW-1:0]  out_tdata,
  input logic                           cfg_ready
);

  import sgsd_pkg::*;

  logic last_cmd_hit_r;

  // remember whether the last delivered result carried a command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_hit_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_cmd_hit_r <= (out_tdata[CommandW-1:0] != '0);
    end
  end

  // a match spoils the history, so the next result is never a command
  a_no_double_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && last_cmd_hit_r) |-> (out_tdata[CommandW-1:0] == '0))
    else $error("command reported on two results in a row");

  // padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OutDataW-1:CommandW] == '0))
    else $error("result padding not zero");

  // the input side is never blocked while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind stick_gesture_sequence_detector sgsd_checker u_sgsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
